@@ rtl/core/frg_pkg.sv @@
// shared types, constants and codes of the falling glyph rain column block
package frg_pkg;

    localparam int MAX_ROWS    = 24;
    localparam int MAX_COLUMNS = 40;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int CELL_AW    = COL_W + ROW_W;
    localparam int CELL_DEPTH = MAX_COLUMNS << ROW_W;
    localparam int VAL_W      = 9;
    localparam int RND_W      = 7;

    localparam logic [ROW_W-1:0] ROWS_MAX = ROW_W'(MAX_ROWS);
    localparam logic [ROW_W-1:0] ROWS_MIN = ROW_W'(4);
    localparam logic [COL_W-1:0] COLS_MAX = COL_W'(MAX_COLUMNS);

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;

    localparam logic [VAL_W-1:0] V_EMPTY = 9'h1FF;
    localparam logic [VAL_W-1:0] V_BLANK = 9'd32;
    localparam logic [VAL_W-1:0] V_HEAD  = 9'd0;
    localparam logic [VAL_W-1:0] V_TRAIL = 9'd1;

    localparam logic [2:0] COLOR_HEAD      = 3'd7;
    localparam logic [7:0] GLYPH_BLANK     = 8'd32;
    localparam logic [7:0] GLYPH_HEAD      = 8'd38;
    localparam logic [7:0] GLYPH_HEAD_ALT  = 8'd183;
    localparam logic [7:0] GLYPH_TRAIL     = 8'd124;
    localparam logic [6:0] RANGE_STD       = 7'd93;
    localparam logic [6:0] RANGE_ALT       = 7'd51;
    localparam logic [7:0] RMIN_STD        = 8'd33;
    localparam logic [7:0] RMIN_ALT        = 8'd166;
    localparam logic [7:0] HIGH_STD        = 8'd123;
    localparam logic [7:0] HIGH_ALT        = 8'd217;

    localparam logic [1:0] BOLD_NONE = 2'd0;
    localparam logic [1:0] BOLD_TAIL = 2'd1;
    localparam logic [1:0] BOLD_HEAD = 2'd2;

    localparam logic [1:0] BMODE_EVEN = 2'd1;

    localparam logic [2:0] CFG_SEED     = 3'd0;
    localparam logic [2:0] CFG_ALL_COLS = 3'd1;
    localparam logic [2:0] CFG_OLD      = 3'd2;
    localparam logic [2:0] CFG_BOLD     = 3'd3;
    localparam logic [2:0] CFG_COLOR    = 3'd4;
    localparam logic [2:0] CFG_ALT_FONT = 3'd5;
    localparam logic [2:0] CFG_ROWS     = 3'd6;

    typedef struct packed {
        logic             mode;
        logic [COL_W-1:0] column;
        logic             new_frame;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [7:0]       glyph;
        logic [2:0]       color;
        logic             bold;
        logic             last;
    } out_t;

    typedef struct packed {
        logic [ROW_W-1:0] space;
        logic [ROW_W-1:0] stream;
        logic [1:0]       rate;
    } prm_t;

    typedef struct packed {
        logic               v_en;
        logic               b_en;
        logic [CELL_AW-1:0] addr;
        logic [VAL_W-1:0]   val;
        logic [1:0]         bold;
    } cell_wr_t;

endpackage

@@ rtl/core/frg_rand.sv @@
// shared random unit: lcg step then bit-serial remainder by a small divisor
module frg_rand
    import frg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             seed_we,
    input  logic [31:0]      seed,
    input  logic             go,
    input  logic [RND_W-1:0] n,
    output logic             done,
    output logic [RND_W-1:0] res
);

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_LOAD = 4'b0010,
        R_DIV  = 4'b0100,
        R_DONE = 4'b1000
    } rstate_t;

    rstate_t          state_reg, state_next;
    logic [31:0]      lcg_reg, lcg_next;
    logic [14:0]      dv_reg, dv_next;
    logic [RND_W-1:0] rem_reg, rem_next;
    logic [RND_W-1:0] n_reg, n_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [RND_W:0]   rem_sh;

    assign rem_sh = {rem_reg, dv_reg[14]};
    assign done   = (state_reg == R_DONE);
    assign res    = rem_reg;

    always_comb
    begin
        state_next = state_reg;
        lcg_next   = lcg_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (seed_we)
                begin
                    lcg_next = (seed == 32'd0) ? 32'd1 : seed;
                end
                else if (go)
                begin
                    lcg_next   = lcg_reg * LCG_MUL + LCG_INC;
                    n_next     = n;
                    state_next = R_LOAD;
                end
            end
            R_LOAD:
            begin
                // (s / 65536) % 32768 is bits 30:16
                dv_next    = lcg_reg[30:16];
                rem_next   = '0;
                cnt_next   = 4'd14;
                state_next = R_DIV;
            end
            R_DIV:
            begin
                if (rem_sh >= {1'b0, n_reg})
                begin
                    rem_next = RND_W'(rem_sh - {1'b0, n_reg});
                end
                else
                begin
                    rem_next = RND_W'(rem_sh);
                end
                dv_next = {dv_reg[13:0], 1'b0};
                if (cnt_reg == 4'd0)
                begin
                    state_next = R_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            lcg_reg   <= 32'd1;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lcg_reg   <= lcg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        n_reg   <= n_next;
    end

endmodule

@@ rtl/core/frg_store.sv @@
// cell value, cell bold and per-column parameter memories
module frg_store
    import frg_pkg::*;
(
    input  logic               clk,
    input  logic [CELL_AW-1:0] rd_addr,
    output logic [VAL_W-1:0]   rd_val,
    output logic [1:0]         rd_bold,
    input  cell_wr_t           wr,
    input  logic [COL_W-1:0]   prm_col,
    output prm_t               prm_rd,
    input  logic               prm_we,
    input  prm_t               prm_wr
);

    logic [VAL_W-1:0] val_mem  [CELL_DEPTH];
    logic [1:0]       bold_mem [CELL_DEPTH];
    prm_t             prm_mem  [MAX_COLUMNS];

    always_ff @(posedge clk)
    begin
        if (wr.v_en)
        begin
            val_mem[wr.addr] <= wr.val;
        end
        if (wr.b_en)
        begin
            bold_mem[wr.addr] <= wr.bold;
        end
        rd_val  <= val_mem[rd_addr];
        rd_bold <= bold_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prm_we)
        begin
            prm_mem[prm_col] <= prm_wr;
        end
        prm_rd <= prm_mem[prm_col];
    end

endmodule

@@ rtl/core/falling_glyph_rain_column_step.sv @@
// falling glyph rain column step: sequencer over the cell store and random unit
//
//   channel   signals                               direction
//   item      start, busy, item                     in, taken on start & !busy
//   result    res_strobe, result                    out, one cycle per word
//   config    cfg_we, cfg_index, cfg_data           in, taken on cfg_we
//
// each random draw runs through the shared lcg and remainder unit
// init: rows+1 cell writes and three draws
// step: a read and a wait state per cell scanned plus one draw per stream, a read and an emit state per row drawn
// reset clears control only; a column reads garbage until it is initialised
// the receiver cannot stall; a result word is shown for one cycle
module falling_glyph_rain_column_step
    import frg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        res_strobe,
    output out_t        result
);

    typedef enum logic [35:0] {
        ST_IDLE    = 36'd1 << 0,
        ST_FIN     = 36'd1 << 1,
        ST_INIT_WR = 36'd1 << 2,
        ST_INIT_SP = 36'd1 << 3,
        ST_INIT_SL = 36'd1 << 4,
        ST_INIT_UR = 36'd1 << 5,
        ST_PRM_RD  = 36'd1 << 6,
        ST_PRM_WT  = 36'd1 << 7,
        ST_PRM_WR  = 36'd1 << 8,
        ST_N_RD0   = 36'd1 << 9,
        ST_N_RD1   = 36'd1 << 10,
        ST_N_HDR   = 36'd1 << 11,
        ST_N_SL    = 36'd1 << 12,
        ST_N_V0    = 36'd1 << 13,
        ST_N_B0    = 36'd1 << 14,
        ST_N_SP    = 36'd1 << 15,
        ST_SC_RD   = 36'd1 << 16,
        ST_SC_WT   = 36'd1 << 17,
        ST_RN_RD   = 36'd1 << 18,
        ST_RN_WT   = 36'd1 << 19,
        ST_TL_Z    = 36'd1 << 20,
        ST_TL_L    = 36'd1 << 21,
        ST_GP_V    = 36'd1 << 22,
        ST_GP_B1   = 36'd1 << 23,
        ST_GP_B2   = 36'd1 << 24,
        ST_GP_CHK  = 36'd1 << 25,
        ST_GP_Z0   = 36'd1 << 26,
        ST_O_RD    = 36'd1 << 27,
        ST_O_WR    = 36'd1 << 28,
        ST_O_R     = 36'd1 << 29,
        ST_O_DEC   = 36'd1 << 30,
        ST_O_3     = 36'd1 << 31,
        ST_O_V     = 36'd1 << 32,
        ST_O_SP    = 36'd1 << 33,
        ST_DRAW_RD = 36'd1 << 34,
        ST_DRAW_EM = 36'd1 << 35
    } state_t;

    state_t           state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [2:0]       frame_reg, frame_next;
    logic [6:0]       i_reg, i_next;
    logic [ROW_W-1:0] z_reg, z_next;
    logic [6:0]       y_reg, y_next;
    logic             sdone_reg, sdone_next;
    logic [1:0]       prevb_reg, prevb_next;
    logic [1:0]       cb0_reg, cb0_next;
    logic [VAL_W-1:0] v0_reg, v0_next;
    logic [VAL_W-1:0] top_reg, top_next;
    logic [VAL_W-1:0] r_reg, r_next;
    logic             spa_reg, spa_next;
    logic             rq_reg, rq_next;
    logic [ROW_W-1:0] sp_reg, sp_next;
    logic [ROW_W-1:0] sl_reg, sl_next;
    logic [1:0]       ur_reg, ur_next;
    logic             strobe_reg, strobe_next;
    out_t             out_reg, out_next;

    logic             all_cols_reg, old_reg, alt_reg;
    logic [1:0]       bold_mode_reg;
    logic [2:0]       color_reg;
    logic [ROW_W-1:0] rows_reg;

    logic [ROW_W-1:0] lc, span, first_row, last_row;
    logic [6:0]       lc7, rn;
    logic [7:0]       rmin, high;
    logic [ROW_W-1:0] rd_row;
    logic [VAL_W-1:0] rd_val, rnd_val;
    logic [1:0]       rd_bold;
    logic             rd_gap, top_gap;
    cell_wr_t         wr;
    prm_t             prm_rd;
    logic             prm_we;
    logic             rnd_go, rnd_done, rnd_fire;
    logic [RND_W-1:0] rnd_n, rnd_res;
    logic             seed_we;
    logic [7:0]       glyph;
    logic [2:0]       cell_color;
    logic             cell_bold;

    assign lc = (rows_reg < ROWS_MIN) ? ROWS_MIN :
                (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    assign lc7       = {1'b0, lc};
    assign span      = lc - ROW_W'(3);
    assign rn        = alt_reg ? RANGE_ALT : RANGE_STD;
    assign rmin      = alt_reg ? RMIN_ALT : RMIN_STD;
    assign high      = alt_reg ? HIGH_ALT : HIGH_STD;
    assign first_row = old_reg ? ROW_W'(0) : ROW_W'(1);
    assign last_row  = old_reg ? lc - ROW_W'(1) : lc;
    assign rd_gap    = (rd_val == V_BLANK) || (rd_val == V_EMPTY);
    assign top_gap   = (top_reg == V_BLANK) || (top_reg == V_EMPTY);
    assign rnd_fire  = rq_reg && rnd_done;
    assign rnd_val   = VAL_W'(rnd_res) + VAL_W'(rmin);
    assign seed_we   = cfg_we && (cfg_index == CFG_SEED);
    assign busy      = (state_reg != ST_IDLE);
    assign res_strobe = strobe_reg;
    assign result    = out_reg;

    frg_rand u_rand (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (seed_we),
        .seed    (cfg_data),
        .go      (rnd_go),
        .n       (rnd_n),
        .done    (rnd_done),
        .res     (rnd_res)
    );

    frg_store u_store (
        .clk     (clk),
        .rd_addr ({col_reg, rd_row}),
        .rd_val  (rd_val),
        .rd_bold (rd_bold),
        .wr      (wr),
        .prm_col (col_reg),
        .prm_rd  (prm_rd),
        .prm_we  (prm_we),
        .prm_wr  ({sp_reg, sl_reg, ur_reg})
    );

    // glyph, color and bold of the cell just read
    always_comb
    begin
        if (rd_val == V_HEAD)
        begin
            glyph = alt_reg ? GLYPH_HEAD_ALT : GLYPH_HEAD;
        end
        else if (rd_val == V_TRAIL)
        begin
            glyph = GLYPH_TRAIL;
        end
        else if (rd_val[VAL_W-1])
        begin
            glyph = GLYPH_BLANK;
        end
        else
        begin
            glyph = rd_val[7:0];
        end
        if ((rd_val == V_HEAD) || (rd_bold == BOLD_HEAD))
        begin
            cell_color = COLOR_HEAD;
            cell_bold  = |bold_mode_reg;
        end
        else
        begin
            cell_color = color_reg;
            if (rd_val == V_TRAIL)
            begin
                cell_bold = |bold_mode_reg;
            end
            else
            begin
                cell_bold = bold_mode_reg[1] || ((bold_mode_reg == BMODE_EVEN) && !rd_val[0]);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        col_next    = col_reg;
        frame_next  = frame_reg;
        i_next      = i_reg;
        z_next      = z_reg;
        y_next      = y_reg;
        sdone_next  = sdone_reg;
        prevb_next  = prevb_reg;
        cb0_next    = cb0_reg;
        v0_next     = v0_reg;
        top_next    = top_reg;
        r_next      = r_reg;
        spa_next    = spa_reg;
        rq_next     = rq_reg;
        sp_next     = sp_reg;
        sl_next     = sl_reg;
        ur_next     = ur_reg;
        strobe_next = 1'b0;
        out_next    = out_reg;
        wr          = '0;
        prm_we      = 1'b0;
        rnd_go      = 1'b0;
        rnd_n       = '0;
        rd_row      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = item.mode;
                    col_next  = item.column;
                    i_next    = '0;
                    if (!item.mode)
                    begin
                        state_next = (item.column < COLS_MAX) ? ST_INIT_WR : ST_FIN;
                    end
                    else
                    begin
                        if (item.new_frame)
                        begin
                            frame_next = (frame_reg >= 3'd4) ? 3'd1 : frame_reg + 3'd1;
                        end
                        state_next = (item.column < COLS_MAX) ? ST_PRM_RD : ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            ST_INIT_WR:
            begin
                wr.v_en = 1'b1;
                wr.b_en = 1'b1;
                wr.addr = {col_reg, i_reg[ROW_W-1:0]};
                wr.val  = (i_reg == 7'd1) ? V_BLANK : V_EMPTY;
                wr.bold = BOLD_NONE;
                if (i_reg == lc7)
                begin
                    state_next = ST_INIT_SP;
                end
                else
                begin
                    i_next = i_reg + 7'd1;
                end
            end
            ST_INIT_SP:
            begin
                rnd_n   = RND_W'(lc);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    sp_next    = ROW_W'(rnd_res) + ROW_W'(1);
                    state_next = ST_INIT_SL;
                end
            end
            ST_INIT_SL:
            begin
                rnd_n   = RND_W'(span);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    sl_next    = ROW_W'(rnd_res) + ROW_W'(3);
                    state_next = ST_INIT_UR;
                end
            end
            ST_INIT_UR:
            begin
                rnd_n   = RND_W'(3);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    ur_next    = 2'(rnd_res) + 2'd1;
                    state_next = ST_PRM_WR;
                end
            end
            ST_PRM_RD:
            begin
                state_next = ST_PRM_WT;
            end
            ST_PRM_WT:
            begin
                sp_next = prm_rd.space;
                sl_next = prm_rd.stream;
                ur_next = prm_rd.rate;
                if ((frame_reg > {1'b0, prm_rd.rate}) || all_cols_reg)
                begin
                    if (old_reg)
                    begin
                        i_next     = lc7 - 7'd1;
                        state_next = ST_O_RD;
                    end
                    else
                    begin
                        state_next = ST_N_RD0;
                    end
                end
                else
                begin
                    state_next = ST_PRM_WR;
                end
            end
            ST_PRM_WR:
            begin
                prm_we = 1'b1;
                i_next = {1'b0, first_row};
                state_next = mode_reg ? ST_DRAW_RD : ST_IDLE;
            end
            ST_N_RD0:
            begin
                rd_row     = ROW_W'(0);
                state_next = ST_N_RD1;
            end
            ST_N_RD1:
            begin
                cb0_next   = rd_bold;
                top_next   = rd_val;
                rd_row     = ROW_W'(1);
                state_next = ST_N_HDR;
            end
            ST_N_HDR:
            begin
                i_next     = '0;
                sdone_next = 1'b0;
                state_next = ST_SC_RD;
                if ((top_reg == V_EMPTY) && (rd_val == V_BLANK))
                begin
                    if (sp_reg != '0)
                    begin
                        sp_next = sp_reg - ROW_W'(1);
                    end
                    else
                    begin
                        state_next = ST_N_SL;
                    end
                end
            end
            ST_N_SL:
            begin
                rnd_n   = RND_W'(span);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    sl_next    = ROW_W'(rnd_res) + ROW_W'(3);
                    state_next = ST_N_V0;
                end
            end
            ST_N_V0:
            begin
                rnd_n   = rn;
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    v0_next    = rnd_val;
                    state_next = ST_N_B0;
                end
            end
            ST_N_B0:
            begin
                rnd_n   = RND_W'(2);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    if (rnd_res == RND_W'(1))
                    begin
                        cb0_next = BOLD_HEAD;
                    end
                    state_next = ST_N_SP;
                end
            end
            ST_N_SP:
            begin
                rnd_n   = RND_W'(lc);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    sp_next    = ROW_W'(rnd_res) + ROW_W'(1);
                    wr.v_en    = 1'b1;
                    wr.b_en    = 1'b1;
                    wr.addr    = {col_reg, ROW_W'(0)};
                    wr.val     = v0_reg;
                    wr.bold    = cb0_reg;
                    state_next = ST_SC_RD;
                end
            end
            // skip the gap above the next stream
            ST_SC_RD:
            begin
                rd_row = i_reg[ROW_W-1:0];
                state_next = (i_reg > lc7) ? ST_PRM_WR : ST_SC_WT;
            end
            ST_SC_WT:
            begin
                i_next = i_reg + 7'd1;
                if (rd_gap)
                begin
                    state_next = ST_SC_RD;
                end
                else
                begin
                    z_next     = i_reg[ROW_W-1:0];
                    y_next     = 7'd1;
                    prevb_next = rd_bold;
                    state_next = ST_RN_RD;
                end
            end
            // walk down the body of the stream
            ST_RN_RD:
            begin
                rd_row = i_reg[ROW_W-1:0];
                state_next = (i_reg > lc7) ? ST_TL_Z : ST_RN_WT;
            end
            ST_RN_WT:
            begin
                if (rd_gap)
                begin
                    state_next = ST_GP_V;
                end
                else
                begin
                    i_next     = i_reg + 7'd1;
                    y_next     = y_reg + 7'd1;
                    prevb_next = rd_bold;
                    state_next = ST_RN_RD;
                end
            end
            // stream ran off the bottom
            ST_TL_Z:
            begin
                wr.v_en    = 1'b1;
                wr.addr    = {col_reg, z_reg};
                wr.val     = V_BLANK;
                state_next = ST_TL_L;
            end
            ST_TL_L:
            begin
                wr.b_en    = 1'b1;
                wr.addr    = {col_reg, lc};
                wr.bold    = BOLD_TAIL;
                state_next = ST_SC_RD;
            end
            ST_GP_V:
            begin
                rnd_n   = rn;
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    wr.v_en    = 1'b1;
                    wr.addr    = {col_reg, i_reg[ROW_W-1:0]};
                    wr.val     = rnd_val;
                    state_next = (prevb_reg == BOLD_HEAD) ? ST_GP_B1 : ST_GP_CHK;
                end
            end
            ST_GP_B1:
            begin
                wr.b_en    = 1'b1;
                wr.addr    = {col_reg, ROW_W'(i_reg - 7'd1)};
                wr.bold    = BOLD_TAIL;
                state_next = ST_GP_B2;
            end
            ST_GP_B2:
            begin
                wr.b_en    = 1'b1;
                wr.addr    = {col_reg, i_reg[ROW_W-1:0]};
                wr.bold    = BOLD_HEAD;
                state_next = ST_GP_CHK;
            end
            ST_GP_CHK:
            begin
                if ((y_reg > {1'b0, sl_reg}) || sdone_reg)
                begin
                    wr.v_en    = 1'b1;
                    wr.addr    = {col_reg, z_reg};
                    wr.val     = V_BLANK;
                    state_next = ST_GP_Z0;
                end
                else
                begin
                    sdone_next = 1'b1;
                    i_next     = i_reg + 7'd1;
                    state_next = ST_SC_RD;
                end
            end
            ST_GP_Z0:
            begin
                wr.v_en    = 1'b1;
                wr.addr    = {col_reg, ROW_W'(0)};
                wr.val     = V_EMPTY;
                sdone_next = 1'b1;
                i_next     = i_reg + 7'd1;
                state_next = ST_SC_RD;
            end
            // old style: shift the column down one row
            ST_O_RD:
            begin
                rd_row     = ROW_W'(i_reg - 7'd1);
                state_next = ST_O_WR;
            end
            ST_O_WR:
            begin
                wr.v_en = 1'b1;
                wr.addr = {col_reg, i_reg[ROW_W-1:0]};
                wr.val  = rd_val;
                if (i_reg == 7'd1)
                begin
                    top_next   = rd_val;
                    state_next = ST_O_R;
                end
                else
                begin
                    i_next     = i_reg - 7'd1;
                    state_next = ST_O_RD;
                end
            end
            ST_O_R:
            begin
                rnd_n   = rn + 7'd8;
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    r_next     = rnd_val;
                    state_next = ST_O_DEC;
                end
            end
            ST_O_DEC:
            begin
                wr.addr    = {col_reg, ROW_W'(0)};
                state_next = ST_PRM_WR;
                if (top_reg == V_HEAD)
                begin
                    wr.v_en = 1'b1;
                    wr.val  = V_TRAIL;
                end
                else if (top_gap)
                begin
                    if (sp_reg != '0)
                    begin
                        wr.v_en = 1'b1;
                        wr.val  = V_BLANK;
                        sp_next = sp_reg - ROW_W'(1);
                    end
                    else
                    begin
                        state_next = ST_O_3;
                    end
                end
                else if ((r_reg > {1'b0, high}) && (top_reg != V_TRAIL))
                begin
                    wr.v_en = 1'b1;
                    wr.val  = V_BLANK;
                end
                else
                begin
                    spa_next   = 1'b0;
                    state_next = ST_O_V;
                end
            end
            ST_O_3:
            begin
                rnd_n   = RND_W'(3);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    if (rnd_res == RND_W'(1))
                    begin
                        wr.v_en    = 1'b1;
                        wr.addr    = {col_reg, ROW_W'(0)};
                        wr.val     = V_HEAD;
                        state_next = ST_O_SP;
                    end
                    else
                    begin
                        spa_next   = 1'b1;
                        state_next = ST_O_V;
                    end
                end
            end
            ST_O_V:
            begin
                rnd_n   = rn;
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    wr.v_en    = 1'b1;
                    wr.addr    = {col_reg, ROW_W'(0)};
                    wr.val     = rnd_val;
                    state_next = spa_reg ? ST_O_SP : ST_PRM_WR;
                end
            end
            ST_O_SP:
            begin
                rnd_n   = RND_W'(lc);
                rnd_go  = !rq_reg;
                rq_next = !rnd_fire;
                if (rnd_fire)
                begin
                    sp_next    = ROW_W'(rnd_res) + ROW_W'(1);
                    state_next = ST_PRM_WR;
                end
            end
            ST_DRAW_RD:
            begin
                rd_row     = i_reg[ROW_W-1:0];
                state_next = ST_DRAW_EM;
            end
            ST_DRAW_EM:
            begin
                strobe_next    = 1'b1;
                out_next.row   = i_reg[ROW_W-1:0] - first_row;
                out_next.glyph = glyph;
                out_next.color = cell_color;
                out_next.bold  = cell_bold;
                out_next.last  = (i_reg[ROW_W-1:0] == last_row);
                if (i_reg[ROW_W-1:0] == last_row)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 7'd1;
                    state_next = ST_DRAW_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '0;
            rq_reg        <= 1'b0;
            strobe_reg    <= 1'b0;
            all_cols_reg  <= 1'b0;
            old_reg       <= 1'b0;
            bold_mode_reg <= 2'd0;
            color_reg     <= 3'd2;
            alt_reg       <= 1'b0;
            rows_reg      <= ROW_W'(24);
        end
        else
        begin
            state_reg  <= state_next;
            frame_reg  <= frame_next;
            rq_reg     <= rq_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ALL_COLS: all_cols_reg  <= cfg_data[0];
                    CFG_OLD:      old_reg       <= cfg_data[0];
                    CFG_BOLD:     bold_mode_reg <= cfg_data[1:0];
                    CFG_COLOR:    color_reg     <= cfg_data[2:0];
                    CFG_ALT_FONT: alt_reg       <= cfg_data[0];
                    CFG_ROWS:     rows_reg      <= cfg_data[ROW_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        col_reg   <= col_next;
        i_reg     <= i_next;
        z_reg     <= z_next;
        y_reg     <= y_next;
        sdone_reg <= sdone_next;
        prevb_reg <= prevb_next;
        cb0_reg   <= cb0_next;
        v0_reg    <= v0_next;
        top_reg   <= top_next;
        r_reg     <= r_next;
        spa_reg   <= spa_next;
        sp_reg    <= sp_next;
        sl_reg    <= sl_next;
        ur_reg    <= ur_next;
        out_reg   <= out_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |=> !res_strobe)
        else $error("result words back to back");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && result.last |-> !busy)
        else $error("block still busy after the last row");

    a_rand_go: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_go |-> !rq_reg)
        else $error("random request issued twice");

endmodule

@@ verif/tb_falling_glyph_rain_column_step.sv @@
// testbench for the falling glyph rain column step block: directed and random items
module tb_falling_glyph_rain_column_step;
    import frg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        res_strobe;
    out_t        result;

    falling_glyph_rain_column_step dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_strobe (res_strobe),
        .result     (result)
    );

    // mirror of the block state
    int          cell_val [0:MAX_ROWS][0:MAX_COLUMNS-1];
    int          cell_bld [0:MAX_ROWS][0:MAX_COLUMNS-1];
    int          gap_left [0:MAX_COLUMNS-1];
    int          trail_len [0:MAX_COLUMNS-1];
    int          speed [0:MAX_COLUMNS-1];
    bit          col_ready [0:MAX_COLUMNS-1];
    int          frame_no;
    logic [31:0] lcg;

    logic        every_frame_r;
    logic        old_r;
    logic [1:0]  bold_r;
    logic [2:0]  color_r;
    logic        alt_r;
    logic [5:0]  rows_r;

    out_t        cells_due[$];
    int          mismatches;
    int          cells_seen;
    int          words_sent;
    int          cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_falling_glyph_rain_column_step: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && res_strobe)
        begin
            cells_seen = cells_seen + 1;
            if (cells_due.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected word row=%0d glyph=%0d", result.row, result.glyph);
            end
            else
            begin
                want = cells_due.pop_front();
                if (result !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp row=%0d glyph=%0d color=%0d bold=%0d last=%0d",
                                 want.row, want.glyph, want.color, want.bold, want.last);
                        $display("         got row=%0d glyph=%0d color=%0d bold=%0d last=%0d",
                                 result.row, result.glyph, result.color, result.bold,
                                 result.last);
                    end
                end
            end
        end
    end

    function automatic int lcg_mod(int unsigned n);
        lcg = lcg * LCG_MUL + LCG_INC;
        return int'(((lcg >> 16) & 32'h7fff) % n);
    endfunction

    function automatic bit is_gap(int v);
        return v == 32 || v == -1;
    endfunction

    function automatic int glyph_code(int v);
        if (v == 0)
            return alt_r ? 183 : 38;
        if (v == 1)
            return 124;
        if (v < 0)
            return 32;
        return v & 255;
    endfunction

    function automatic void advance_new(int c, int L, int span, int rn, int rmin);
        int i;
        int y;
        int z;
        bit done;
        done = 0;
        if (cell_val[0][c] == -1 && cell_val[1][c] == 32 && gap_left[c] > 0)
            gap_left[c]--;
        else if (cell_val[0][c] == -1 && cell_val[1][c] == 32)
        begin
            trail_len[c] = lcg_mod(span) + 3;
            cell_val[0][c] = lcg_mod(rn) + rmin;
            if (lcg_mod(2) == 1)
                cell_bld[0][c] = 2;
            gap_left[c] = lcg_mod(L) + 1;
        end
        i = 0;
        while (i <= L)
        begin
            while (i <= L && is_gap(cell_val[i][c]))
                i++;
            if (i > L)
                break;
            z = i;
            y = 0;
            while (i <= L && !is_gap(cell_val[i][c]))
            begin
                i++;
                y++;
            end
            if (i > L)
            begin
                cell_val[z][c] = 32;
                cell_bld[L][c] = 1;
                continue;
            end
            cell_val[i][c] = lcg_mod(rn) + rmin;
            if (cell_bld[i-1][c] == 2)
            begin
                cell_bld[i-1][c] = 1;
                cell_bld[i][c] = 2;
            end
            if (y > trail_len[c] || done)
            begin
                cell_val[z][c] = 32;
                cell_val[0][c] = -1;
            end
            done = 1;
            i++;
        end
    endfunction

    function automatic void advance_old(int c, int L, int rn, int rmin, int high);
        int r;
        int top;
        for (int i = L - 1; i >= 1; i--)
            cell_val[i][c] = cell_val[i-1][c];
        r = lcg_mod(rn + 8) + rmin;
        top = cell_val[1][c];
        if (top == 0)
            cell_val[0][c] = 1;
        else if (is_gap(top))
        begin
            if (gap_left[c] > 0)
            begin
                cell_val[0][c] = 32;
                gap_left[c]--;
            end
            else
            begin
                if (lcg_mod(3) == 1)
                    cell_val[0][c] = 0;
                else
                    cell_val[0][c] = lcg_mod(rn) + rmin;
                gap_left[c] = lcg_mod(L) + 1;
            end
        end
        else if (r > high && top != 1)
            cell_val[0][c] = 32;
        else
            cell_val[0][c] = lcg_mod(rn) + rmin;
    endfunction

    // works out the cells one accepted word will draw
    function automatic void rain_column(in_t w);
        int L;
        int span;
        int rn;
        int rmin;
        int high;
        int bm;
        int c;
        int first;
        int lastrow;
        int v;
        out_t o;
        L = rows_r < 4 ? 4 : (rows_r > MAX_ROWS ? MAX_ROWS : rows_r);
        span = L - 3;
        rn = alt_r ? 51 : 93;
        rmin = alt_r ? 166 : 33;
        high = alt_r ? 217 : 123;
        bm = bold_r == 3 ? 2 : bold_r;
        c = w.column;
        if (w.mode == 1'b0)
        begin
            if (c >= MAX_COLUMNS)
                return;
            for (int i = 0; i <= L; i++)
            begin
                cell_val[i][c] = -1;
                cell_bld[i][c] = 0;
            end
            gap_left[c] = lcg_mod(L) + 1;
            trail_len[c] = lcg_mod(span) + 3;
            cell_val[1][c] = 32;
            speed[c] = lcg_mod(3) + 1;
            return;
        end
        if (w.new_frame)
        begin
            frame_no++;
            if (frame_no > 4)
                frame_no = 1;
        end
        if (c >= MAX_COLUMNS)
            return;
        if (frame_no > speed[c] || every_frame_r)
        begin
            if (old_r)
                advance_old(c, L, rn, rmin, high);
            else
                advance_new(c, L, span, rn, rmin);
        end
        first = old_r ? 0 : 1;
        lastrow = old_r ? L - 1 : L;
        for (int i = first; i <= lastrow; i++)
        begin
            v = cell_val[i][c];
            o.row = ROW_W'(i - first);
            o.glyph = 8'(glyph_code(v));
            if (v == 0 || cell_bld[i][c] == 2)
            begin
                o.color = COLOR_HEAD;
                o.bold = bm != 0;
            end
            else
            begin
                o.color = color_r;
                if (v == 1)
                    o.bold = bm != 0;
                else
                    o.bold = bm == 2 || (bm == 1 && (v & 1) == 0);
            end
            o.last = i == lastrow;
            cells_due.push_back(o);
        end
    endfunction

    task automatic send_word(logic mode, int column, logic nf);
        in_t w;
        w.mode = mode;
        w.column = COL_W'(column);
        w.new_frame = nf;
        start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
        rain_column(w);
        words_sent++;
        if (mode == 1'b0 && column < MAX_COLUMNS)
            col_ready[column] = 1;
    endtask

    task automatic idle_gap(int pct);
        int n;
        n = 0;
        while (n < 20 && $urandom_range(99) < pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (cells_due.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SEED:
            begin
                lcg = data == 0 ? 32'd1 : data;
            end
            CFG_ALL_COLS: every_frame_r = data[0];
            CFG_OLD:      old_r = data[0];
            CFG_BOLD:     bold_r = data[1:0];
            CFG_COLOR:    color_r = data[2:0];
            CFG_ALT_FONT: alt_r = data[0];
            CFG_ROWS:
            begin
                rows_r = data[5:0];
                // cells above the old row count were never written
                foreach (col_ready[k])
                    col_ready[k] = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] sd, bit ev, bit old, int bm, int colr, bit alt, int r);
        drain();
        write_reg(CFG_SEED, sd);
        write_reg(CFG_ALL_COLS, 32'(ev));
        write_reg(CFG_OLD, 32'(old));
        write_reg(CFG_BOLD, 32'(bm));
        write_reg(CFG_COLOR, 32'(colr));
        write_reg(CFG_ALT_FONT, 32'(alt));
        write_reg(CFG_ROWS, 32'(r));
    endtask

    task automatic test_directed;
        set_all(32'd0, 1, 0, 0, 0, 0, 24);
        send_word(1'b0, 0, 1'b1);
        send_word(1'b0, 39, 1'b0);
        send_word(1'b0, 40, 1'b0);
        send_word(1'b0, 63, 1'b1);
        send_word(1'b1, 40, 1'b1);
        send_word(1'b1, 63, 1'b1);
        repeat (6) send_word(1'b1, 0, 1'b1);
        send_word(1'b1, 39, 1'b0);
        set_all(32'hffff_ffff, 1, 1, 3, 7, 1, 63);
        send_word(1'b0, 0, 1'b0);
        repeat (6) send_word(1'b1, 0, 1'b1);
        set_all(32'h1234_5678, 0, 0, 1, 5, 1, 0);
        send_word(1'b0, 21, 1'b0);
        repeat (5) send_word(1'b1, 21, 1'b1);
    endtask

    task automatic test_random(int n, int pct);
        int p;
        int c;
        int ready[$];
        for (int k = 0; k < n; k++)
        begin
            ready.delete();
            foreach (col_ready[j])
                if (col_ready[j])
                    ready.push_back(j);
            p = $urandom_range(99);
            if (ready.size() == 0 || p < 10)
                send_word(1'b0, $urandom_range(63), 1'($urandom_range(1)));
            else if (p < 15)
                send_word(1'b1, $urandom_range(63, 40), 1'($urandom_range(1)));
            else
            begin
                c = ready[$urandom_range(ready.size() - 1)];
                send_word(1'b1, c, 1'($urandom_range(1)));
            end
            idle_gap(pct);
        end
    endtask

    task automatic test_phases;
        set_all($urandom, 0, 0, 2, $urandom_range(7), 0, 4);
        test_random(17, 0);
        set_all($urandom, 0, 1, 1, $urandom_range(7), 0, 24);
        test_random(17, 77);
        set_all($urandom, $urandom_range(1), 0, $urandom_range(3), 2, 1,
                $urandom_range(63, 4));
        test_random(17, 0);
        set_all($urandom, 1, 1, 0, $urandom_range(7), 1, 0);
        test_random(17, 15);
        set_all($urandom, 0, $urandom_range(1), 3, 7, $urandom_range(1),
                $urandom_range(24, 4));
        test_random(17, 77);
    endtask

    initial
    begin
        cycles = 0;
        mismatches = 0;
        cells_seen = 0;
        words_sent = 0;
        frame_no = 0;
        lcg = 32'd1;
        every_frame_r = 0;
        old_r = 0;
        bold_r = 0;
        color_r = 3'd2;
        alt_r = 0;
        rows_r = 6'd24;
        foreach (col_ready[k])
            col_ready[k] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_phases();
        drain();
        repeat (50) @(posedge clk);

        $display("sent %0d words over eight register settings, checked %0d drawn cells",
                 words_sent, cells_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_falling_glyph_rain_column_step: PASS");
        else
            $display("tb_falling_glyph_rain_column_step: FAIL");
        $finish;
    end

endmodule
